### design/bxl_pkg.sv
package bxl_pkg;

  typedef enum logic [7:0] {
    PH_HDR0 = 8'b0000_0001,
    PH_HDR1 = 8'b0000_0010,
    PH_SLO  = 8'b0000_0100,
    PH_SHI  = 8'b0000_1000,
    PH_ELO  = 8'b0001_0000,
    PH_EHI  = 8'b0010_0000,
    PH_DATA = 8'b0100_0000,
    PH_BANK = 8'b1000_0000
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SMALL  = 3'd1,
    ST_NOHDR  = 3'd2,
    ST_FTRUNC = 3'd3,
    ST_BTRUNC = 3'd4
  } status_e;

  localparam logic [7:0]  MarkByte  = 8'hFF;
  localparam logic [15:0] BankAddr  = 16'hFFFE;
  localparam logic [15:0] VecLoAddr = 16'hFFFC;
  localparam logic [15:0] VecHiAddr = 16'hFFFD;
  localparam logic [1:0]  VecBoth   = 2'b11;

  typedef struct packed {
    logic        write_valid;
    logic [7:0]  write_bank;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
    logic        file_done;
    logic [2:0]  status;
    logic        start_cpu;
  } result_t;

endpackage

### design/bxl_if.sv
interface bxl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface bxl_out_if;
  logic        valid;
  logic        ready;
  logic        write_valid;
  logic [7:0]  write_bank;
  logic [15:0] write_addr;
  logic [7:0]  write_data;
  logic        file_done;
  logic [2:0]  status;
  logic        start_cpu;

  modport source (
    output valid, output write_valid, output write_bank, output write_addr,
    output write_data, output file_done, output status, output start_cpu,
    input ready
  );
  modport sink (
    input valid, input write_valid, input write_bank, input write_addr,
    input write_data, input file_done, input status, input start_cpu,
    output ready
  );
endinterface

### design/bxl_parser.sv
module bxl_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output bxl_pkg::result_t  result_o
);

  bxl_pkg::phase_e  phase_q, phase_d;
  logic [7:0]       low_q, low_d;
  logic [15:0]      start_q, start_d;
  logic [15:0]      end_q, end_d;
  logic [15:0]      addr_q, addr_d;
  logic [7:0]       bank_q, bank_d;
  logic [1:0]       vf_q, vf_d;
  logic             mark_q, mark_d;
  logic             err_q, err_d;

  logic             fin;
  bxl_pkg::status_e code;
  logic [15:0]      word;

  assign word = {byte_i, low_q};

  always_comb begin
    phase_d  = phase_q;
    low_d    = low_q;
    start_d  = start_q;
    end_d    = end_q;
    addr_d   = addr_q;
    bank_d   = bank_q;
    vf_d     = vf_q;
    mark_d   = mark_q;
    err_d    = err_q;
    fin      = 1'b0;
    code     = bxl_pkg::ST_OK;
    result_o = '0;

    if (err_q) begin
      if (last_i) begin
        err_d   = 1'b0;
        phase_d = bxl_pkg::PH_HDR0;
      end
    end else begin
      unique case (phase_q)
        bxl_pkg::PH_HDR0: begin
          if (last_i) begin
            fin  = 1'b1;
            code = bxl_pkg::ST_SMALL;
          end else if (byte_i != bxl_pkg::MarkByte) begin
            fin  = 1'b1;
            code = bxl_pkg::ST_NOHDR;
          end else begin
            phase_d = bxl_pkg::PH_HDR1;
          end
        end
        bxl_pkg::PH_HDR1: begin
          if (byte_i != bxl_pkg::MarkByte) begin
            fin  = 1'b1;
            code = bxl_pkg::ST_NOHDR;
          end else if (last_i) begin
            fin  = 1'b1;
            code = bxl_pkg::ST_FTRUNC;
          end else begin
            mark_d  = 1'b1;
            phase_d = bxl_pkg::PH_SLO;
          end
        end
        bxl_pkg::PH_SLO: begin
          if (last_i) begin
            fin  = 1'b1;
            code = bxl_pkg::ST_FTRUNC;
          end else begin
            low_d   = byte_i;
            phase_d = bxl_pkg::PH_SHI;
          end
        end
        bxl_pkg::PH_SHI: begin
          if (last_i) begin
            fin  = 1'b1;
            code = bxl_pkg::ST_FTRUNC;
          end else if (!mark_q && low_q == bxl_pkg::MarkByte &&
                       byte_i == bxl_pkg::MarkByte) begin
            mark_d  = 1'b1;
            phase_d = bxl_pkg::PH_SLO;
          end else begin
            start_d = word;
            phase_d = bxl_pkg::PH_ELO;
          end
        end
        bxl_pkg::PH_ELO: begin
          if (last_i) begin
            fin  = 1'b1;
            code = bxl_pkg::ST_FTRUNC;
          end else begin
            low_d   = byte_i;
            phase_d = bxl_pkg::PH_EHI;
          end
        end
        bxl_pkg::PH_EHI: begin
          end_d = word;
          if (last_i || start_q > word) begin
            fin  = 1'b1;
            code = bxl_pkg::ST_BTRUNC;
          end else if (start_q == bxl_pkg::BankAddr && word == bxl_pkg::BankAddr) begin
            phase_d = bxl_pkg::PH_BANK;
          end else begin
            addr_d  = start_q;
            phase_d = bxl_pkg::PH_DATA;
          end
        end
        bxl_pkg::PH_BANK: begin
          bank_d  = byte_i;
          mark_d  = 1'b0;
          phase_d = bxl_pkg::PH_SLO;
          fin     = last_i;
        end
        bxl_pkg::PH_DATA: begin
          result_o.write_valid = 1'b1;
          result_o.write_bank  = bank_q;
          result_o.write_addr  = addr_q;
          result_o.write_data  = byte_i;
          if (addr_q == bxl_pkg::VecLoAddr) vf_d[0] = 1'b1;
          if (addr_q == bxl_pkg::VecHiAddr) vf_d[1] = 1'b1;
          if (addr_q == end_q) begin
            mark_d  = 1'b0;
            phase_d = bxl_pkg::PH_SLO;
            fin     = last_i;
          end else begin
            addr_d = addr_q + 16'd1;
            if (last_i) begin
              fin  = 1'b1;
              code = bxl_pkg::ST_BTRUNC;
            end
          end
        end
        default: phase_d = bxl_pkg::PH_HDR0;
      endcase

      if (fin) begin
        result_o.file_done = 1'b1;
        result_o.status    = code;
        result_o.start_cpu = (code == bxl_pkg::ST_OK) && (vf_d == bxl_pkg::VecBoth);
        phase_d = bxl_pkg::PH_HDR0;
        low_d   = '0;
        start_d = '0;
        end_d   = '0;
        addr_d  = '0;
        bank_d  = '0;
        vf_d    = '0;
        mark_d  = 1'b0;
        err_d   = (code != bxl_pkg::ST_OK) && !last_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bxl_pkg::PH_HDR0;
      low_q   <= '0;
      start_q <= '0;
      end_q   <= '0;
      addr_q  <= '0;
      bank_q  <= '0;
      vf_q    <= '0;
      mark_q  <= 1'b0;
      err_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      low_q   <= low_d;
      start_q <= start_d;
      end_q   <= end_d;
      addr_q  <= addr_d;
      bank_q  <= bank_d;
      vf_q    <= vf_d;
      mark_q  <= mark_d;
      err_q   <= err_d;
    end
  end

`ifndef ASSERT_OFF
  a_err_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && err_q |-> !result_o.write_valid && !result_o.file_done)
    else $error("output produced while error latched");

  a_done_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && result_o.file_done |=> phase_q == bxl_pkg::PH_HDR0 && vf_q == 2'b00)
    else $error("state not cleared after file end");

  a_start_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.start_cpu |-> result_o.file_done && result_o.status == bxl_pkg::ST_OK)
    else $error("start_cpu without successful end");

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("phase register not one-hot");
`endif

endmodule

### design/bxl_out_reg.sv
module bxl_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  bxl_pkg::result_t  result_i,
  output logic              free_o,
  bxl_out_if.source         out_o
);

  logic             valid_q;
  bxl_pkg::result_t data_q;

  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.write_valid = data_q.write_valid;
  assign out_o.write_bank  = data_q.write_bank;
  assign out_o.write_addr  = data_q.write_addr;
  assign out_o.write_data  = data_q.write_data;
  assign out_o.file_done   = data_q.file_done;
  assign out_o.status      = data_q.status;
  assign out_o.start_cpu   = data_q.start_cpu;

endmodule

### design/banked_xex_stream_loader.sv
// Each result is registered and output in the cycle after its byte's transaction.
// Throughput: one byte per cycle unless stalled; the parser state register updates on every
// accepted byte. A new byte is taken while the output register is empty or being drained.
// Reset (rst_ni low, asynchronous): parser returns to the first header byte,
// bank, vector flags and error latch clear, and the output register empties.
module banked_xex_stream_loader (
  input  logic       clk_i,
  input  logic       rst_ni,
  bxl_in_if.sink     in_i,
  bxl_out_if.source  out_o
);

  logic             free;
  logic             accept;
  bxl_pkg::result_t result;

  assign in_i.ready = free;
  assign accept     = in_i.valid && free;

  bxl_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_i.byte_in),
    .last_i   (in_i.last_byte),
    .result_o (result)
  );

  bxl_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .result_i (result),
    .free_o   (free),
    .out_o    (out_o)
  );

endmodule
